// ===== hdl/dca_pkg.sv =====
// ----------------------------------------------------------------------------
// dca_pkg
// Shared types and constants of the double-cell arithmetic unit.
// ----------------------------------------------------------------------------
package dca_pkg;

    localparam int CellBitsDefault = 32;
    localparam int FieldBits       = 32;

    localparam logic [2:0] FUNC_MUL = 3'd0;
    localparam logic [2:0] FUNC_DIV = 3'd1;
    localparam logic [2:0] FUNC_ADD = 3'd2;
    localparam logic [2:0] FUNC_SUB = 3'd3;
    localparam logic [2:0] FUNC_NEG = 3'd4;

    typedef struct packed {
        logic [2:0]           func;
        logic [FieldBits-1:0] x_low;
        logic [FieldBits-1:0] x_high;
        logic [FieldBits-1:0] y_low;
        logic [FieldBits-1:0] y_high;
    } t_in_item;

    typedef struct packed {
        logic [FieldBits-1:0] result_low;
        logic [FieldBits-1:0] result_high;
    } t_out_item;

endpackage

// ===== hdl/dca_cell.sv =====
// ----------------------------------------------------------------------------
// dca_cell
// One pipeline cell: one restoring divide step on the partial remainder and,
// in the first CELL_BITS cells, one shift-add multiply step.
// ----------------------------------------------------------------------------
module dca_cell
    import dca_pkg::*;
#(
    parameter int CELL_BITS = CellBitsDefault,
    parameter int STEP      = 0
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic                   i_valid,
    input  logic [2:0]             i_func,
    input  logic [CELL_BITS-1:0]   i_rem,
    input  logic [CELL_BITS-1:0]   i_quo,
    input  logic [CELL_BITS-1:0]   i_dvs,
    input  logic [2*CELL_BITS-1:0] i_acc,
    input  logic [CELL_BITS-1:0]   i_res_lo,
    input  logic [CELL_BITS-1:0]   i_res_hi,
    output logic                   o_valid,
    output logic [2:0]             o_func,
    output logic [CELL_BITS-1:0]   o_rem,
    output logic [CELL_BITS-1:0]   o_quo,
    output logic [CELL_BITS-1:0]   o_dvs,
    output logic [2*CELL_BITS-1:0] o_acc,
    output logic [CELL_BITS-1:0]   o_res_lo,
    output logic [CELL_BITS-1:0]   o_res_hi
);

    // divide: rem=partial remainder, acc=dividend shifting out at the top
    // with quotient bits entering at the bottom;
    // multiply: rem=multiplicand, quo=multiplier, acc=product
    localparam bit DoMul = (STEP < CELL_BITS);
    localparam int B     = DoMul ? (CELL_BITS - 1 - STEP) : 0;

    logic                   r_valid;
    logic [2:0]             r_func;
    logic [CELL_BITS-1:0]   r_rem, r_quo, r_dvs, r_lo, r_hi;
    logic [2*CELL_BITS-1:0] r_acc;
    logic [CELL_BITS-1:0]   n_rem, n_quo;
    logic [2*CELL_BITS-1:0] n_acc;
    logic [CELL_BITS:0]     w_trial;
    logic [CELL_BITS:0]     w_diff;

    always_comb begin
        n_rem   = i_rem;
        n_quo   = i_quo;
        n_acc   = i_acc;
        w_trial = {i_rem, i_acc[2*CELL_BITS-1]};
        w_diff  = w_trial - {1'b0, i_dvs};
        if (i_func == FUNC_DIV) begin
            if (!w_diff[CELL_BITS] || i_rem[CELL_BITS-1]) begin
                n_rem = w_diff[CELL_BITS-1:0];
                n_acc = {i_acc[2*CELL_BITS-2:0], 1'b1};
            end else begin
                n_rem = w_trial[CELL_BITS-1:0];
                n_acc = {i_acc[2*CELL_BITS-2:0], 1'b0};
            end
        end else if (i_func == FUNC_MUL) begin
            if (DoMul && i_quo[B])
                n_acc = i_acc + ({{CELL_BITS{1'b0}}, i_rem} << B);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
        if (i_en) begin
            r_func <= i_func;
            r_rem  <= n_rem;
            r_quo  <= n_quo;
            r_dvs  <= i_dvs;
            r_acc  <= n_acc;
            r_lo   <= i_res_lo;
            r_hi   <= i_res_hi;
        end
    end

    assign o_valid  = r_valid;
    assign o_func   = r_func;
    assign o_rem    = r_rem;
    assign o_quo    = r_quo;
    assign o_dvs    = r_dvs;
    assign o_acc    = r_acc;
    assign o_res_lo = r_lo;
    assign o_res_hi = r_hi;

endmodule

// ===== hdl/double_cell_arith_unit_top.sv =====
// Throughput: one item per cycle; a chain of 2*CELL_BITS cells does one
// divide step each, and the first CELL_BITS cells one multiply step each.
// The chain stalls as a whole when the output register is full and not taken.
// Reset (synchronous, active low) clears all valid bits; payload is not reset.
// ----------------------------------------------------------------------------
// double_cell_arith_unit_top
// Stack-machine double-cell multiply, divide, add, subtract and negate.
// ----------------------------------------------------------------------------
module double_cell_arith_unit_top
    import dca_pkg::*;
#(
    parameter int CELL_BITS = CellBitsDefault
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_in_item  i_data,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_item o_data
);

    localparam int N     = CELL_BITS;
    localparam int STEPS = 2 * N;

    logic               w_en;
    logic [STEPS:0]     v_valid;
    logic [2:0]         v_func  [STEPS+1];
    logic [N-1:0]       v_rem   [STEPS+1];
    logic [N-1:0]       v_quo   [STEPS+1];
    logic [N-1:0]       v_dvs   [STEPS+1];
    logic [2*N-1:0]     v_acc   [STEPS+1];
    logic [N-1:0]       v_lo    [STEPS+1];
    logic [N-1:0]       v_hi    [STEPS+1];

    logic [N-1:0]   w_xl, w_xh, w_yl, w_yh;
    logic [2*N-1:0] w_xd, w_yd, w_sum;

    logic           r_ovalid;
    t_out_item      r_odata;
    t_out_item      n_odata;

    // advance the whole chain unless the output register is stuck
    assign w_en    = !r_ovalid || i_ready;
    assign o_ready = w_en;

    assign w_xl = i_data.x_low[N-1:0];
    assign w_xh = i_data.x_high[N-1:0];
    assign w_yl = i_data.y_low[N-1:0];
    assign w_yh = i_data.y_high[N-1:0];
    assign w_xd = {w_xh, w_xl};
    assign w_yd = {w_yh, w_yl};

    always_comb begin
        unique case (i_data.func)
            FUNC_ADD: w_sum = w_xd + w_yd;
            FUNC_SUB: w_sum = w_xd - w_yd;
            FUNC_NEG: w_sum = '0 - w_xd;
            default:  w_sum = '0;
        endcase
    end

    // divide runs over the full double dividend so the remainder stays exact
    // and the quotient wraps to its low cell
    assign v_valid[0] = i_valid;
    assign v_func[0]  = i_data.func;
    assign v_rem[0]   = (i_data.func == FUNC_DIV) ? '0 : w_xl;
    assign v_quo[0]   = w_yl;
    assign v_dvs[0]   = w_yl;
    assign v_acc[0]   = (i_data.func == FUNC_DIV) ? w_xd : '0;
    assign v_lo[0]    = w_sum[N-1:0];
    assign v_hi[0]    = w_sum[2*N-1:N];

    for (genvar g = 0; g < STEPS; g++) begin : g_cell
        dca_cell #(.CELL_BITS(N), .STEP(g)) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_en     (w_en),
            .i_valid  (v_valid[g]),
            .i_func   (v_func[g]),
            .i_rem    (v_rem[g]),
            .i_quo    (v_quo[g]),
            .i_dvs    (v_dvs[g]),
            .i_acc    (v_acc[g]),
            .i_res_lo (v_lo[g]),
            .i_res_hi (v_hi[g]),
            .o_valid  (v_valid[g+1]),
            .o_func   (v_func[g+1]),
            .o_rem    (v_rem[g+1]),
            .o_quo    (v_quo[g+1]),
            .o_dvs    (v_dvs[g+1]),
            .o_acc    (v_acc[g+1]),
            .o_res_lo (v_lo[g+1]),
            .o_res_hi (v_hi[g+1])
        );
    end

    always_comb begin
        n_odata = '0;
        unique case (v_func[STEPS])
            FUNC_MUL: begin
                n_odata.result_low  = FieldBits'(v_acc[STEPS][N-1:0]);
                n_odata.result_high = FieldBits'(v_acc[STEPS][2*N-1:N]);
            end
            FUNC_DIV: begin
                if (v_dvs[STEPS] == '0) begin
                    n_odata.result_low  = FieldBits'({N{1'b1}});
                    n_odata.result_high = FieldBits'({N{1'b1}});
                end else begin
                    n_odata.result_low  = FieldBits'(v_rem[STEPS]);
                    n_odata.result_high = FieldBits'(v_acc[STEPS][N-1:0]);
                end
            end
            FUNC_ADD, FUNC_SUB, FUNC_NEG: begin
                n_odata.result_low  = FieldBits'(v_lo[STEPS]);
                n_odata.result_high = FieldBits'(v_hi[STEPS]);
            end
            default: n_odata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_en) begin
            r_ovalid <= v_valid[STEPS];
        end
        if (w_en) begin
            r_odata <= n_odata;
        end
    end

    assign o_valid = r_ovalid;
    assign o_data  = r_odata;

endmodule

// ===== hdl/dca_checker.sv =====
// ----------------------------------------------------------------------------
// dca_checker
// Port-level checks of the double-cell arithmetic unit.
// ----------------------------------------------------------------------------
module dca_checker
    import dca_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_valid,
    input logic      o_ready,
    input t_in_item  i_data,
    input logic      o_valid,
    input logic      i_ready,
    input t_out_item o_data
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data))
        else $error("result changed while stalled");

    // ready drops only when the output is full and not taken
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready == (!o_valid || i_ready))
        else $error("ready mismatch");

    // no result right after reset
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("valid after reset");

endmodule

bind double_cell_arith_unit_top dca_checker u_dca_checker (.*);

// ===== tb/sv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Drives operations into the double-cell arithmetic unit and checks each
// result in order against a predictor of multiply, divide, add, subtract
// and negate, with random idling on both sides.
// ----------------------------------------------------------------------------
module testbench;
    import dca_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CellBits   = 32;
    localparam int NumRandom  = 600;
    localparam int Latency    = 2 * CellBits;
    localparam int NumDirect  = 20;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_valid;
    logic      o_ready;
    t_in_item  i_data;
    logic      o_valid;
    logic      i_ready;
    t_out_item o_data;

    t_out_item expected_results[$];
    int        error_count;
    int        result_count;
    bit        sender_done;
    bit        long_hold;
    int        op_count[8];

    double_cell_arith_unit_top #(.CELL_BITS(CellBits)) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #2000000;
        $display("Timeout waiting for results");
        $display("*** FAILED ***");
        $finish;
    end

    function automatic t_out_item compute_double(t_in_item item);
        t_out_item  res;
        logic [63:0] xd;
        logic [63:0] yd;
        logic [63:0] sum;
        xd  = {item.x_high, item.x_low};
        yd  = {item.y_high, item.y_low};
        sum = 64'd0;
        res = '0;
        case (item.func)
            FUNC_MUL: sum = 64'(item.x_low) * 64'(item.y_low);
            FUNC_DIV: begin
                if (item.y_low == 0) begin
                    sum = '1;
                end else begin
                    sum[63:32] = 32'(xd / 64'(item.y_low));
                    sum[31:0]  = 32'(xd % 64'(item.y_low));
                end
            end
            FUNC_ADD: sum = xd + yd;
            FUNC_SUB: sum = xd - yd;
            FUNC_NEG: sum = 64'd0 - xd;
            default:  sum = 64'd0;
        endcase
        res.result_high = sum[63:32];
        res.result_low  = sum[31:0];
        return res;
    endfunction

    task automatic send_item(t_in_item item, bit do_gap);
        int gap;
        gap = do_gap ? $urandom_range(0, 10) : 0;
        repeat (gap) @(negedge i_clk);
        i_valid = 1'b1;
        i_data  = item;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        expected_results.push_back(compute_double(item));
        op_count[item.func]++;
        @(negedge i_clk);
        i_valid = 1'b0;
    endtask

    function automatic logic [31:0] rand_cell();
        case ($urandom_range(0, 5))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom_range(0, 15);
            3: return 32'h8000_0000 | $urandom_range(0, 3);
            default: return $urandom;
        endcase
    endfunction

    // Directed table; rows without a typed result rely on the predictor
    t_in_item  dir_in[NumDirect];
    t_out_item dir_out[NumDirect];
    bit        dir_typed[NumDirect];

    task automatic set_row(int idx, logic [2:0] f, logic [31:0] xl, logic [31:0] xh,
                           logic [31:0] yl, logic [31:0] yh, bit typed,
                           logic [31:0] rl, logic [31:0] rh);
        dir_in[idx]    = '{func: f, x_low: xl, x_high: xh, y_low: yl, y_high: yh};
        dir_typed[idx] = typed;
        dir_out[idx]   = '{result_low: rl, result_high: rh};
    endtask

    // Sender
    initial begin
        t_in_item item;
        int       tmp;
        i_valid     = 1'b0;
        i_data      = '0;
        sender_done = 1'b0;
        set_row(0,  FUNC_MUL, '1, 0, '1, 0, 1, 32'h0000_0001, 32'hFFFF_FFFE);
        set_row(1,  FUNC_MUL, 0, '1, '1, '1, 1, 0, 0);
        set_row(2,  FUNC_DIV, 5, 5, 0, 7, 1, '1, '1);
        set_row(3,  FUNC_DIV, 0, '1, 1, 0, 1, 0, 0);
        set_row(4,  FUNC_DIV, '1, 32'hFFFF_FFFE, '1, 0, 1, 32'hFFFF_FFFE, '1);
        set_row(5,  FUNC_DIV, 7, 0, 2, '1, 1, 1, 3);
        set_row(6,  FUNC_ADD, '1, '1, 1, 0, 1, 0, 0);
        set_row(7,  FUNC_ADD, '1, 0, 1, 0, 1, 0, 1);
        set_row(8,  FUNC_SUB, 0, 0, 1, 0, 1, '1, '1);
        set_row(9,  FUNC_SUB, 0, 32'h8000_0000, 0, 1, 1, 0, 32'h7FFF_FFFF);
        set_row(10, FUNC_NEG, 1, 0, '1, '1, 1, '1, '1);
        set_row(11, FUNC_NEG, 0, 32'h8000_0000, 0, 0, 1, 0, 32'h8000_0000);
        set_row(12, FUNC_NEG, 0, 0, 5, 5, 1, 0, 0);
        set_row(13, 3'd5, '1, '1, '1, '1, 1, 0, 0);
        set_row(14, 3'd6, 1, 2, 3, 4, 1, 0, 0);
        set_row(15, 3'd7, '1, 0, '1, 0, 1, 0, 0);
        set_row(16, FUNC_DIV, 32'h1234_5678, 32'h0000_0042, 32'h0000_1000, 0, 0, 0, 0);
        set_row(17, FUNC_MUL, 32'hDEAD_BEEF, 0, 32'h1234_5678, 0, 0, 0, 0);
        set_row(18, FUNC_ADD, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1, 0, 0, 0);
        set_row(19, FUNC_DIV, 32'hFFFF_FFFF, 32'h0000_0003, 32'h0000_0004, '1, 0, 0, 0);
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        @(negedge i_clk);
        for (int i = 0; i < NumDirect; i++) begin
            if (dir_typed[i] && compute_double(dir_in[i]) !== dir_out[i]) begin
                $error("table row %0d: predictor disagrees with typed result", i);
                error_count++;
            end
            send_item(dir_in[i], 1'b1);
        end
        // Offer back to back while the receiver holds off, so the pipe fills
        for (int n = 0; n < NumRandom; n++) begin
            if (n == 300) begin
                // Pause until the block has drained
                while (expected_results.size() != 0) @(negedge i_clk);
            end
            tmp = $urandom_range(0, 15);
            item.func   = (tmp < 15) ? 3'(tmp % 5) : 3'($urandom_range(5, 7));
            item.x_low  = rand_cell();
            item.x_high = rand_cell();
            item.y_low  = rand_cell();
            item.y_high = rand_cell();
            if (item.func == FUNC_DIV && $urandom_range(0, 2) == 0) begin
                item.x_high = item.x_high % (item.y_low == 0 ? 32'd1 : item.y_low);
            end
            send_item(item, !(n < 80 || (n >= 400 && n < 450)));
        end
        sender_done = 1'b1;
    end

    // Receiver and checker
    initial begin
        int        stall;
        int        drain;
        t_out_item want;
        i_ready      = 1'b0;
        i_rst_n      = 1'b0;
        error_count  = 0;
        result_count = 0;
        long_hold    = 1'b0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        drain   = 0;
        while (!sender_done || expected_results.size() != 0 || drain < Latency + 10) begin
            if (result_count == 30 && !long_hold) begin
                long_hold = 1'b1;
                i_ready   = 1'b0;
                stall     = 0;
                while (stall < 3 * Latency) begin
                    @(negedge i_clk);
                    stall++;
                end
            end
            if (result_count < 60 || (result_count > 400 && result_count < 500)) begin
                stall = 0;
            end else begin
                stall = $urandom_range(0, 10);
            end
            i_ready = 1'b0;
            repeat (stall) @(negedge i_clk);
            i_ready = 1'b1;
            @(posedge i_clk);
            if (o_valid) begin
                drain = 0;
                result_count++;
                if (expected_results.size() == 0) begin
                    $error("unexpected result low=%h high=%h",
                           o_data.result_low, o_data.result_high);
                    error_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (o_data.result_low !== want.result_low) begin
                        $error("result_low: expected %h, got %h",
                               want.result_low, o_data.result_low);
                        error_count++;
                    end
                    if (o_data.result_high !== want.result_high) begin
                        $error("result_high: expected %h, got %h",
                               want.result_high, o_data.result_high);
                        error_count++;
                    end
                end
            end else if (sender_done && expected_results.size() == 0) begin
                drain++;
            end
            @(negedge i_clk);
        end
        $display("Covered %0d results: mul %0d, div %0d, add %0d, sub %0d, neg %0d",
                 result_count, op_count[0], op_count[1], op_count[2], op_count[3],
                 op_count[4]);
        $display("Unknown operation codes sent: %0d, with long output stall and drain",
                 op_count[5] + op_count[6] + op_count[7]);
        if (error_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hdl/dca_pkg.sv
hdl/dca_cell.sv
hdl/double_cell_arith_unit_top.sv
hdl/dca_checker.sv
tb/sv/testbench.sv
